### rtl/psr_pkg.sv
`timescale 1ns / 1ps

package psr_pkg;

  // Field widths of the vertex and of the step register.
  localparam int PosW      = 24;
  localparam int AttrW     = 16;
  localparam int StepW     = 23;
  localparam int NumFields = 8;
  localparam int FieldIdxW = 3;

  // Interpolation position and increment (Q0.16; the increment can reach one).
  localparam int TW   = 16;
  localparam int IncW = 17;

  // Squared length, integer root, and divider widths.
  localparam int D2W  = 50;
  localparam int LenW = 25;
  localparam int RemW = 41;
  localparam int MulW = 26;
  localparam int ProdW = 52;

  // Controller iteration counter.
  localparam int CntW = 5;

  // 0.99 in Q0.16 is 64881; the insert count divides one less than that.
  localparam logic [15:0] CountDividend = 16'd64880;

  // Positions are handled in offset binary.
  localparam logic [PosW-1:0] SignFlip = 24'h800000;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MS_DX,
    MS_DY,
    MS_STEP,
    MS_FIELD
  } mul_sel_e;

  // Kind of point being emitted.
  typedef enum logic [2:0] {
    K_START = 3'b001,
    K_INS   = 3'b010,
    K_CLOSE = 3'b100
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load_in;
    logic                 mul_en;
    mul_sel_e             mul_sel;
    logic [FieldIdxW-1:0] field_idx;
    logic                 acc_load;
    logic                 acc_add;
    logic                 sqrt_init;
    logic                 sqrt_step;
    logic                 div1_init;
    logic                 div2_init;
    logic                 div_step;
    logic                 cnt_load;
    logic                 ins_next;
    kind_e                kind;
    logic                 meta_load;
    logic                 store_prev;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gt;
    logic last;
    logic more;
  } dp_stat_t;

endpackage

### rtl/psr_dp.sv
`timescale 1ns / 1ps

module psr_dp import psr_pkg::*; #(
  parameter int MAX_INSERTS = 60
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_stat_t                stat_o,
  input  logic                    cfg_we_i,
  input  logic [StepW-1:0]        cfg_wdata_i,
  input  logic signed [PosW-1:0]  pos_x_i,
  input  logic signed [PosW-1:0]  pos_y_i,
  input  logic [AttrW-1:0]        thick_right_i,
  input  logic [AttrW-1:0]        thick_left_i,
  input  logic [AttrW-1:0]        alpha_i,
  input  logic [AttrW-1:0]        red_i,
  input  logic [AttrW-1:0]        green_i,
  input  logic [AttrW-1:0]        blue_i,
  input  logic                    last_vertex_i,
  output logic signed [PosW-1:0]  out_x_o,
  output logic signed [PosW-1:0]  out_y_o,
  output logic [AttrW-1:0]        out_thick_right_o,
  output logic [AttrW-1:0]        out_thick_left_o,
  output logic [AttrW-1:0]        out_alpha_o,
  output logic [AttrW-1:0]        out_red_o,
  output logic [AttrW-1:0]        out_green_o,
  output logic [AttrW-1:0]        out_blue_o,
  output logic                    inserted_o,
  output logic                    capped_o,
  output logic                    end_of_run_o
);

  localparam int CW = $clog2(MAX_INSERTS + 1);

  logic [StepW-1:0] step_q;
  logic [PosW-1:0]  cur_q  [NumFields];
  logic [PosW-1:0]  prev_q [NumFields];
  logic [PosW-1:0]  outf_q [NumFields];
  logic             last_q;

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_a_ext, mul_b_ext, prod_q;
  logic signed [LenW-1:0]  dx, dy, diff_f;
  logic [PosW-1:0]         base_q;
  logic [FieldIdxW-1:0]    wf_q;
  logic                    wv_q;
  logic signed [ProdW-1:0] rnd, shd;
  logic [MulW-1:0]         res;

  logic [D2W-1:0]  acc_q;
  logic [D2W-1:0]  sq_n_q, sq_r_q, sq_bit_q, sq_sum;
  logic [RemW-1:0] rem_q, dv_q;
  logic [IncW-1:0] q_q, inc_q;
  logic [CW-1:0]   count_q, k_q;
  logic            cap_q;
  logic [TW-1:0]   t_q;
  logic            ins_q, capd_q, end_q;

  // Step register, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // Current and previous vertex, positions in offset binary.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cur_q[0] <= pos_x_i ^ SignFlip;
      cur_q[1] <= pos_y_i ^ SignFlip;
      cur_q[2] <= {8'b0, thick_right_i};
      cur_q[3] <= {8'b0, thick_left_i};
      cur_q[4] <= {8'b0, alpha_i};
      cur_q[5] <= {8'b0, red_i};
      cur_q[6] <= {8'b0, green_i};
      cur_q[7] <= {8'b0, blue_i};
      last_q   <= last_vertex_i;
    end
    if (cmd_i.store_prev) begin
      prev_q <= cur_q;
    end
  end

  // Shared multiplier operands.
  assign dx     = $signed({1'b0, cur_q[0]}) - $signed({1'b0, prev_q[0]});
  assign dy     = $signed({1'b0, cur_q[1]}) - $signed({1'b0, prev_q[1]});
  assign diff_f = $signed({1'b0, cur_q[cmd_i.field_idx]})
                - $signed({1'b0, prev_q[cmd_i.field_idx]});

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_DX: begin
        mul_a = MulW'(dx);
        mul_b = MulW'(dx);
      end
      MS_DY: begin
        mul_a = MulW'(dy);
        mul_b = MulW'(dy);
      end
      MS_STEP: begin
        mul_a = $signed({3'b0, step_q});
        mul_b = $signed({3'b0, step_q});
      end
      MS_FIELD: begin
        mul_a = (cmd_i.kind == K_INS) ? MulW'(diff_f) : '0;
        mul_b = $signed({10'b0, t_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_a_ext = ProdW'(mul_a);
  assign mul_b_ext = ProdW'(mul_b);

  // Product register, plus the base value and field index for the write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
    end else begin
      wv_q <= cmd_i.mul_en && (cmd_i.mul_sel == MS_FIELD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a_ext * mul_b_ext;
      wf_q   <= cmd_i.field_idx;
      base_q <= (cmd_i.kind == K_CLOSE) ? cur_q[cmd_i.field_idx]
                                        : prev_q[cmd_i.field_idx];
    end
  end

  // Interpolated field: base plus rounded scaled difference.
  assign rnd = prod_q + ProdW'(32768);
  assign shd = rnd >>> 16;
  assign res = {2'b0, base_q} + shd[MulW-1:0];

  always_ff @(posedge clk_i) begin
    if (wv_q) begin
      outf_q[wf_q] <= res[PosW-1:0];
    end
  end

  // Squared length accumulation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      acc_q <= prod_q[D2W-1:0];
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q[D2W-1:0];
    end
  end

  // Integer square root, one result bit per cycle.
  assign sq_sum = sq_r_q + sq_bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      sq_n_q   <= acc_q;
      sq_r_q   <= '0;
      sq_bit_q <= D2W'(1) << 48;
    end else if (cmd_i.sqrt_step) begin
      if (sq_n_q >= sq_sum) begin
        sq_n_q <= sq_n_q - sq_sum;
        sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // Restoring divider shared by the increment and the insert count.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div1_init) begin
      rem_q <= {2'b0, step_q, 16'b0};
      dv_q  <= {sq_r_q[LenW-1:0], 16'b0};
      q_q   <= '0;
    end else if (cmd_i.div2_init) begin
      inc_q <= q_q;
      rem_q <= RemW'(CountDividend);
      dv_q  <= {8'b0, q_q, 16'b0};
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dv_q) begin
        rem_q <= rem_q - dv_q;
        q_q   <= {q_q[IncW-2:0], 1'b1};
      end else begin
        q_q   <= {q_q[IncW-2:0], 1'b0};
      end
      dv_q <= dv_q >> 1;
    end
  end

  // Insert count, cap flag, insert index and interpolation position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      count_q <= '0;
      cap_q   <= 1'b0;
      k_q     <= '0;
      t_q     <= '0;
    end else begin
      if (cmd_i.cnt_load) begin
        if (q_q > IncW'(MAX_INSERTS)) begin
          count_q <= CW'(MAX_INSERTS);
          cap_q   <= 1'b1;
        end else begin
          count_q <= q_q[CW-1:0];
          cap_q   <= 1'b0;
        end
      end
      if (cmd_i.ins_next) begin
        k_q <= k_q + 1'b1;
        t_q <= t_q + inc_q[TW-1:0];
      end
    end
  end

  // Flags of the result being assembled.
  always_ff @(posedge clk_i) begin
    if (cmd_i.meta_load) begin
      ins_q  <= (cmd_i.kind == K_INS);
      capd_q <= cap_q && (cmd_i.kind != K_CLOSE);
      end_q  <= (cmd_i.kind == K_CLOSE) || (!(k_q < count_q) && !last_q);
    end
  end

  assign stat_o.gt   = (step_q != '0) && (acc_q > prod_q[D2W-1:0]);
  assign stat_o.last = last_q;
  assign stat_o.more = (k_q < count_q);

  assign out_x_o           = outf_q[0] ^ SignFlip;
  assign out_y_o           = outf_q[1] ^ SignFlip;
  assign out_thick_right_o = outf_q[2][AttrW-1:0];
  assign out_thick_left_o  = outf_q[3][AttrW-1:0];
  assign out_alpha_o       = outf_q[4][AttrW-1:0];
  assign out_red_o         = outf_q[5][AttrW-1:0];
  assign out_green_o       = outf_q[6][AttrW-1:0];
  assign out_blue_o        = outf_q[7][AttrW-1:0];
  assign inserted_o        = ins_q;
  assign capped_o          = capd_q;
  assign end_of_run_o      = end_q;

endmodule

### rtl/psr_ctrl.sv
`timescale 1ns / 1ps

module psr_ctrl import psr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_SQRT = 9'b000000100,
    S_DIV1 = 9'b000001000,
    S_DIV2 = 9'b000010000,
    S_CNT  = 9'b000100000,
    S_EMIT = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_TAIL = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  kind_e           kind_q, kind_d;
  logic            have_prev_q, have_prev_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      kind_q      <= K_START;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
      have_prev_q <= have_prev_d;
    end
  end

  // Sequencer: length, then root and two divisions when the segment is longer than the step, then one point at a time.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    have_prev_d = have_prev_q;
    cmd_o       = '0;
    cmd_o.mul_sel = MS_DX;
    cmd_o.kind    = kind_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d   = '0;
          state_d = have_prev_q ? S_MUL : S_TAIL;
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + 1'b1;
        priority if (cnt_q == CntW'(0)) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MS_DX;
        end else if (cnt_q == CntW'(1)) begin
          cmd_o.acc_load = 1'b1;
          cmd_o.mul_en   = 1'b1;
          cmd_o.mul_sel  = MS_DY;
        end else if (cnt_q == CntW'(2)) begin
          cmd_o.acc_add = 1'b1;
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MS_STEP;
        end else begin
          cnt_d = '0;
          if (stat_i.gt) begin
            cmd_o.sqrt_init = 1'b1;
            state_d = S_SQRT;
          end else begin
            kind_d  = K_START;
            state_d = S_EMIT;
          end
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(LenW - 1)) begin
          cnt_d   = '0;
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd_o.div1_init = (cnt_q == '0);
        cmd_o.div_step  = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(IncW)) begin
          cnt_d   = '0;
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd_o.div2_init = (cnt_q == '0);
        cmd_o.div_step  = (cnt_q != '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(IncW)) begin
          cnt_d   = '0;
          state_d = S_CNT;
        end
      end
      S_CNT: begin
        cmd_o.cnt_load = 1'b1;
        kind_d  = K_START;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q < CntW'(NumFields)) begin
          cmd_o.mul_en    = 1'b1;
          cmd_o.mul_sel   = MS_FIELD;
          cmd_o.field_idx = cnt_q[FieldIdxW-1:0];
        end else begin
          cmd_o.meta_load = 1'b1;
          cnt_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          priority if (kind_q == K_CLOSE) begin
            have_prev_d = 1'b0;
            state_d     = S_IDLE;
          end else if (stat_i.more) begin
            cmd_o.ins_next = 1'b1;
            kind_d  = K_INS;
            state_d = S_EMIT;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (stat_i.last) begin
          kind_d  = K_CLOSE;
          state_d = S_EMIT;
        end else begin
          cmd_o.store_prev = 1'b1;
          have_prev_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

### rtl/polyline_step_resampler_unit.sv
`timescale 1ns / 1ps

// Polyline step resampler. Vertices are taken one request at a time; each
// request holds the block until all of its results are delivered. A
// segment longer than the step first runs the bit-serial square root and
// two 17-step divisions for the increment and the insert count. Each
// result is built one field per cycle on the one shared multiplier, then
// the flags, and waits in the output register until taken. A new step
// value should be written only while idle, so that it applies from the
// next segment; the block itself does not enforce this.
module polyline_step_resampler_unit import psr_pkg::*; #(
  parameter int MAX_INSERTS = 60
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [StepW-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [PosW-1:0]  pos_x_i,
  input  logic signed [PosW-1:0]  pos_y_i,
  input  logic [AttrW-1:0]        thick_right_i,
  input  logic [AttrW-1:0]        thick_left_i,
  input  logic [AttrW-1:0]        alpha_i,
  input  logic [AttrW-1:0]        red_i,
  input  logic [AttrW-1:0]        green_i,
  input  logic [AttrW-1:0]        blue_i,
  input  logic                    last_vertex_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PosW-1:0]  out_x_o,
  output logic signed [PosW-1:0]  out_y_o,
  output logic [AttrW-1:0]        out_thick_right_o,
  output logic [AttrW-1:0]        out_thick_left_o,
  output logic [AttrW-1:0]        out_alpha_o,
  output logic [AttrW-1:0]        out_red_o,
  output logic [AttrW-1:0]        out_green_o,
  output logic [AttrW-1:0]        out_blue_o,
  output logic                    inserted_o,
  output logic                    capped_o,
  output logic                    end_of_run_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  psr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Arithmetic and storage.
  psr_dp #(
    .MAX_INSERTS (MAX_INSERTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .thick_right_i     (thick_right_i),
    .thick_left_i      (thick_left_i),
    .alpha_i           (alpha_i),
    .red_i             (red_i),
    .green_i           (green_i),
    .blue_i            (blue_i),
    .last_vertex_i     (last_vertex_i),
    .out_x_o           (out_x_o),
    .out_y_o           (out_y_o),
    .out_thick_right_o (out_thick_right_o),
    .out_thick_left_o  (out_thick_left_o),
    .out_alpha_o       (out_alpha_o),
    .out_red_o         (out_red_o),
    .out_green_o       (out_green_o),
    .out_blue_o        (out_blue_o),
    .inserted_o        (inserted_o),
    .capped_o          (capped_o),
    .end_of_run_o      (end_of_run_o)
  );

endmodule

### rtl/psr_checker.sv
`timescale 1ns / 1ps

module psr_checker import psr_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [PosW-1:0] out_x_o,
  input logic                   end_of_run_o
);

  // A stalled result stays offered with the same position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o))
    else $error("stalled result changed");

  // An accepted request makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after a request");

  // No request is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken with a result pending");

  // After a result is taken the next one needs more work before it is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result offered right after a taken one");

  // The last result of a request returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && end_of_run_o |=> ##1 !in_stall_o || !$past(in_stall_o))
    else $error("block stays busy after the end of a run");

endmodule

bind polyline_step_resampler_unit psr_checker u_psr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_x_o      (out_x_o),
  .end_of_run_o (end_of_run_o)
);
